// File: sv/tld_pkg.sv
package tld_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LINE_W = 7;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KILL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EOF   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP  = 3'd7;

  localparam int unsigned MB_CRNL    = 0;
  localparam int unsigned MB_NOCR    = 1;
  localparam int unsigned MB_NLCR    = 2;
  localparam int unsigned MB_UCLC    = 3;
  localparam int unsigned MB_CANON   = 4;
  localparam int unsigned MB_ISIG    = 5;
  localparam int unsigned MB_ECHO    = 6;
  localparam int unsigned MB_ECHOCTL = 7;

  localparam logic [BYTE_W-1:0] RST_MODE  = 8'd241;
  localparam logic [BYTE_W-1:0] RST_INTR  = 8'd3;
  localparam logic [BYTE_W-1:0] RST_QUIT  = 8'd28;
  localparam logic [BYTE_W-1:0] RST_ERASE = 8'd127;
  localparam logic [BYTE_W-1:0] RST_KILL  = 8'd21;
  localparam logic [BYTE_W-1:0] RST_EOF   = 8'd4;
  localparam logic [BYTE_W-1:0] RST_START = 8'd17;
  localparam logic [BYTE_W-1:0] RST_STOP  = 8'd19;

  localparam logic [BYTE_W-1:0] CH_CR      = 8'd13;
  localparam logic [BYTE_W-1:0] CH_NL      = 8'd10;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [BYTE_W-1:0] CH_DEL     = 8'd127;
  localparam logic [BYTE_W-1:0] CH_CARET   = 8'd94;
  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'd65;
  localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'd90;
  localparam logic [BYTE_W-1:0] CASE_OFS   = 8'd32;
  localparam logic [BYTE_W-1:0] CTRL_OFS   = 8'd64;

  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_INTR = 2'd1;
  localparam logic [1:0] SIG_QUIT = 2'd2;

  localparam logic [1:0] ECHO_NONE = 2'd0;
  localparam logic [1:0] ECHO_ONE  = 2'd1;
  localparam logic [1:0] ECHO_TWO  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DEC    = 5'b00010,
    S_TAKE   = 5'b00100,
    S_ED_RD  = 5'b01000,
    S_ED_CHK = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    EK_EMPTY,
    EK_REFUSED,
    EK_SIGNAL,
    EK_STORE,
    EK_TAKE,
    EK_DEL_NOW,
    EK_DEL_PEND
  } emit_kind_t;

  typedef struct packed {
    logic is_take;
    logic empty;
    logic full;
    logic cr_drop;
    logic edit;
    logic kill;
    logic pause_hit;
    logic sig_hit;
    logic can_remove;
    logic echo_on;
    logic out_free;
  } tld_status_t;

  typedef struct packed {
    logic       accept;
    logic       rd_en;
    logic       rd_tail;
    logic       store;
    logic       take;
    logic       remove;
    logic       set_stop;
    logic       capture;
    logic       emit;
    emit_kind_t kind;
    logic       last;
  } tld_cmd_t;

  function automatic logic is_ctrl(input logic [BYTE_W-1:0] c);
    return (c < CH_SPACE) || c[BYTE_W-1];
  endfunction

endpackage

// File: sv/tld_ram.sv
module tld_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/tld_ctrl.sv
module tld_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tld_pkg::tld_status_t st,
  output tld_pkg::tld_cmd_t    cmd
);

  tld_pkg::state_t state_r, state_nxt;
  logic            pend_r, pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tld_pkg::S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign in_stall = (state_r != tld_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    cmd.kind  = tld_pkg::EK_EMPTY;
    unique case (state_r)
      tld_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = tld_pkg::S_DEC;
        end
      end
      tld_pkg::S_DEC: begin
        priority if (st.is_take) begin
          if (!st.empty) begin
            cmd.rd_en   = 1'b1;
            cmd.rd_tail = 1'b1;
            state_nxt   = tld_pkg::S_TAKE;
          end else if (st.out_free) begin
            cmd.emit  = 1'b1;
            cmd.kind  = tld_pkg::EK_EMPTY;
            cmd.last  = 1'b1;
            state_nxt = tld_pkg::S_IDLE;
          end
        end else if (st.full) begin
          if (st.out_free) begin
            cmd.emit  = 1'b1;
            cmd.kind  = tld_pkg::EK_REFUSED;
            cmd.last  = 1'b1;
            state_nxt = tld_pkg::S_IDLE;
          end
        end else if (st.cr_drop) begin
          if (st.out_free) begin
            cmd.emit  = 1'b1;
            cmd.kind  = tld_pkg::EK_EMPTY;
            cmd.last  = 1'b1;
            state_nxt = tld_pkg::S_IDLE;
          end
        end else if (st.edit) begin
          pend_nxt  = 1'b0;
          state_nxt = tld_pkg::S_ED_RD;
        end else if (st.pause_hit) begin
          if (st.out_free) begin
            cmd.set_stop = 1'b1;
            cmd.emit     = 1'b1;
            cmd.kind     = tld_pkg::EK_EMPTY;
            cmd.last     = 1'b1;
            state_nxt    = tld_pkg::S_IDLE;
          end
        end else if (st.sig_hit) begin
          if (st.out_free) begin
            cmd.emit  = 1'b1;
            cmd.kind  = tld_pkg::EK_SIGNAL;
            cmd.last  = 1'b1;
            state_nxt = tld_pkg::S_IDLE;
          end
        end else begin
          if (st.out_free) begin
            cmd.store = 1'b1;
            cmd.emit  = 1'b1;
            cmd.kind  = tld_pkg::EK_STORE;
            cmd.last  = 1'b1;
            state_nxt = tld_pkg::S_IDLE;
          end
        end
      end
      tld_pkg::S_TAKE: begin
        if (st.out_free) begin
          cmd.take  = 1'b1;
          cmd.emit  = 1'b1;
          cmd.kind  = tld_pkg::EK_TAKE;
          cmd.last  = 1'b1;
          state_nxt = tld_pkg::S_IDLE;
        end
      end
      tld_pkg::S_ED_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = tld_pkg::S_ED_CHK;
      end
      tld_pkg::S_ED_CHK: begin
        priority if (pend_r) begin
          // previous removal waits for its echo until we know whether it was the last
          if (st.out_free) begin
            cmd.emit = 1'b1;
            cmd.kind = tld_pkg::EK_DEL_PEND;
            cmd.last = !st.can_remove;
            if (st.can_remove) begin
              cmd.remove  = 1'b1;
              cmd.capture = 1'b1;
              state_nxt   = tld_pkg::S_ED_RD;
            end else begin
              pend_nxt  = 1'b0;
              state_nxt = tld_pkg::S_IDLE;
            end
          end
        end else if (st.can_remove && st.kill) begin
          cmd.remove = 1'b1;
          if (st.echo_on) begin
            cmd.capture = 1'b1;
            pend_nxt    = 1'b1;
          end
          state_nxt = tld_pkg::S_ED_RD;
        end else if (st.can_remove) begin
          if (st.out_free) begin
            cmd.remove = 1'b1;
            cmd.emit   = 1'b1;
            cmd.kind   = st.echo_on ? tld_pkg::EK_DEL_NOW : tld_pkg::EK_EMPTY;
            cmd.last   = 1'b1;
            state_nxt  = tld_pkg::S_IDLE;
          end
        end else begin
          if (st.out_free) begin
            cmd.emit  = 1'b1;
            cmd.kind  = tld_pkg::EK_EMPTY;
            cmd.last  = 1'b1;
            state_nxt = tld_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = tld_pkg::S_IDLE;
        pend_nxt  = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/tld_datapath.sv
module tld_datapath #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_operation,
  input  logic [tld_pkg::BYTE_W-1:0]      in_received_byte,
  input  logic                            cfg_valid,
  input  logic [tld_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tld_pkg::BYTE_W-1:0]      cfg_data,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [1:0]                      out_echo_count,
  output logic [tld_pkg::BYTE_W-1:0]      out_echo_first,
  output logic [tld_pkg::BYTE_W-1:0]      out_echo_second,
  output logic [1:0]                      out_signal_raised,
  output logic                            out_refused,
  output logic                            out_cooked_valid,
  output logic [tld_pkg::BYTE_W-1:0]      out_cooked_byte,
  output logic                            out_output_stopped,
  output logic [tld_pkg::LINE_W-1:0]      out_lines_ready,
  output logic                            out_last_of_run,
  input  tld_pkg::tld_cmd_t               cmd,
  output tld_pkg::tld_status_t            st
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [tld_pkg::LINE_W-1:0] LINE_MAX = tld_pkg::LINE_W'(RING_DEPTH);

  logic [tld_pkg::BYTE_W-1:0] mode_r, intr_r, quit_r, erase_r, kill_r, eof_r, start_r, stop_ch_r;
  logic                       op_r;
  logic [tld_pkg::BYTE_W-1:0] byte_r;
  logic [PTR_W-1:0]           head_r, head_nxt, tail_r, tail_nxt;
  logic [tld_pkg::LINE_W-1:0] line_r, line_nxt;
  logic                       stopped_r, stopped_nxt;
  logic                       pend_two_r;

  logic                       out_valid_r;
  logic [1:0]                 cnt_r;
  logic [tld_pkg::BYTE_W-1:0] e1_r, e2_r, cb_r;
  logic [1:0]                 sig_r;
  logic                       refd_r, cv_r, stp_r, last_r;
  logic [tld_pkg::LINE_W-1:0] lines_r;

  logic [1:0]                 cnt_c;
  logic [tld_pkg::BYTE_W-1:0] e1_c, e2_c, cb_c;
  logic [1:0]                 sig_c;
  logic                       refd_c, cv_c;

  logic [tld_pkg::BYTE_W-1:0] mapped;
  logic                       cr_drop;
  logic [PTR_W-1:0]           head_next, head_prev, tail_next, rd_addr;
  logic [tld_pkg::BYTE_W-1:0] rd_data;
  logic                       echo_on, del_two;

  tld_ram #(
    .WIDTH(tld_pkg::BYTE_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk    (clk),
    .wr_en  (cmd.store),
    .wr_addr(head_r),
    .wr_data(mapped),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign head_next = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
  assign head_prev = (head_r == '0) ? PTR_LAST : head_r - 1'b1;
  assign tail_next = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
  assign rd_addr   = cmd.rd_tail ? tail_r : head_prev;
  assign echo_on   = mode_r[tld_pkg::MB_ECHO];

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= tld_pkg::RST_MODE;
      intr_r    <= tld_pkg::RST_INTR;
      quit_r    <= tld_pkg::RST_QUIT;
      erase_r   <= tld_pkg::RST_ERASE;
      kill_r    <= tld_pkg::RST_KILL;
      eof_r     <= tld_pkg::RST_EOF;
      start_r   <= tld_pkg::RST_START;
      stop_ch_r <= tld_pkg::RST_STOP;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tld_pkg::CFG_MODE:  mode_r    <= cfg_data;
        tld_pkg::CFG_INTR:  intr_r    <= cfg_data;
        tld_pkg::CFG_QUIT:  quit_r    <= cfg_data;
        tld_pkg::CFG_ERASE: erase_r   <= cfg_data;
        tld_pkg::CFG_KILL:  kill_r    <= cfg_data;
        tld_pkg::CFG_EOF:   eof_r     <= cfg_data;
        tld_pkg::CFG_START: start_r   <= cfg_data;
        tld_pkg::CFG_STOP:  stop_ch_r <= cfg_data;
      endcase
    end
  end

  // input mapping
  always_comb begin
    mapped  = byte_r;
    cr_drop = 1'b0;
    if (byte_r == tld_pkg::CH_CR) begin
      if (mode_r[tld_pkg::MB_CRNL]) begin
        mapped = tld_pkg::CH_NL;
      end else if (mode_r[tld_pkg::MB_NOCR]) begin
        cr_drop = 1'b1;
      end
    end else if (byte_r == tld_pkg::CH_NL && mode_r[tld_pkg::MB_NLCR]) begin
      mapped = tld_pkg::CH_CR;
    end
    if (mode_r[tld_pkg::MB_UCLC] && mapped >= tld_pkg::CH_UPPER_A
        && mapped <= tld_pkg::CH_UPPER_Z) begin
      mapped = mapped + tld_pkg::CASE_OFS;
    end
  end

  always_comb begin
    st            = '0;
    st.is_take    = op_r;
    st.empty      = (head_r == tail_r);
    st.full       = (head_next == tail_r);
    st.cr_drop    = cr_drop;
    st.edit       = mode_r[tld_pkg::MB_CANON] && (mapped == kill_r || mapped == erase_r);
    st.kill       = (mapped == kill_r);
    st.pause_hit  = mode_r[tld_pkg::MB_CANON] && (mapped == stop_ch_r || mapped == start_r);
    st.sig_hit    = mode_r[tld_pkg::MB_ISIG] && (mapped == intr_r || mapped == quit_r);
    st.can_remove = (head_r != tail_r) && (rd_data != tld_pkg::CH_NL) && (rd_data != eof_r);
    st.echo_on    = echo_on;
    st.out_free   = !out_valid_r || !out_stall;
  end

  // ring pointers, line count, stopped flag
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    line_nxt    = line_r;
    stopped_nxt = stopped_r;
    if (cmd.store) begin
      head_nxt = head_next;
      if ((mapped == tld_pkg::CH_NL || mapped == eof_r) && line_r < LINE_MAX) begin
        line_nxt = line_r + 1'b1;
      end
    end
    if (cmd.remove) begin
      head_nxt = head_prev;
    end
    if (cmd.take) begin
      tail_nxt = tail_next;
      if ((rd_data == tld_pkg::CH_NL || rd_data == eof_r) && line_r != '0) begin
        line_nxt = line_r - 1'b1;
      end
    end
    if (cmd.set_stop) begin
      stopped_nxt = (mapped == stop_ch_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      line_r    <= '0;
      stopped_r <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      line_r    <= line_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_operation;
      byte_r <= in_received_byte;
    end
    if (cmd.capture) begin
      pend_two_r <= tld_pkg::is_ctrl(rd_data);
    end
  end

  // result payload
  assign del_two = (cmd.kind == tld_pkg::EK_DEL_PEND) ? pend_two_r : tld_pkg::is_ctrl(rd_data);

  always_comb begin
    cnt_c  = tld_pkg::ECHO_NONE;
    e1_c   = '0;
    e2_c   = '0;
    sig_c  = tld_pkg::SIG_NONE;
    refd_c = 1'b0;
    cv_c   = 1'b0;
    cb_c   = '0;
    unique case (cmd.kind)
      tld_pkg::EK_EMPTY: begin
      end
      tld_pkg::EK_REFUSED: begin
        refd_c = 1'b1;
      end
      tld_pkg::EK_SIGNAL: begin
        sig_c = (mapped == intr_r) ? tld_pkg::SIG_INTR : tld_pkg::SIG_QUIT;
      end
      tld_pkg::EK_STORE: begin
        if (echo_on) begin
          if (mapped == tld_pkg::CH_NL) begin
            cnt_c = tld_pkg::ECHO_TWO;
            e1_c  = tld_pkg::CH_NL;
            e2_c  = tld_pkg::CH_CR;
          end else if (tld_pkg::is_ctrl(mapped)) begin
            if (mode_r[tld_pkg::MB_ECHOCTL]) begin
              cnt_c = tld_pkg::ECHO_TWO;
              e1_c  = tld_pkg::CH_CARET;
              e2_c  = mapped + tld_pkg::CTRL_OFS;
            end
          end else begin
            cnt_c = tld_pkg::ECHO_ONE;
            e1_c  = mapped;
          end
        end
      end
      tld_pkg::EK_TAKE: begin
        cv_c = 1'b1;
        cb_c = rd_data;
      end
      tld_pkg::EK_DEL_NOW, tld_pkg::EK_DEL_PEND: begin
        cnt_c = del_two ? tld_pkg::ECHO_TWO : tld_pkg::ECHO_ONE;
        e1_c  = tld_pkg::CH_DEL;
        e2_c  = del_two ? tld_pkg::CH_DEL : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cnt_r   <= cnt_c;
      e1_r    <= e1_c;
      e2_r    <= e2_c;
      sig_r   <= sig_c;
      refd_r  <= refd_c;
      cv_r    <= cv_c;
      cb_r    <= cb_c;
      stp_r   <= stopped_nxt;
      lines_r <= line_nxt;
      last_r  <= cmd.last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_echo_count     = cnt_r;
  assign out_echo_first     = e1_r;
  assign out_echo_second    = e2_r;
  assign out_signal_raised  = sig_r;
  assign out_refused        = refd_r;
  assign out_cooked_valid   = cv_r;
  assign out_cooked_byte    = cb_r;
  assign out_output_stopped = stp_r;
  assign out_lines_ready    = lines_r;
  assign out_last_of_run    = last_r;

endmodule

// File: sv/terminal_line_discipline_top.sv
// sequencing: an accepted request is decoded in S_DEC and its result is registered;
//   a take reads the ring tail and emits in S_TAKE, an erase reads in S_ED_RD and checks in
//   S_ED_CHK; a kill repeats both per removed byte, one result each when echo is on
// flow: the ring memory read is registered; in_stall holds new requests until S_IDLE, so no
//   request is taken before the previous one is done; a stalled result holds the next one back
// reset: synchronous active-low rst_n empties the ring, clears line count and stopped
//   flag and loads the default control bytes; ring contents are not cleared
module terminal_line_discipline_top #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [tld_pkg::BYTE_W-1:0]    in_received_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_echo_count,
  output logic [tld_pkg::BYTE_W-1:0]    out_echo_first,
  output logic [tld_pkg::BYTE_W-1:0]    out_echo_second,
  output logic [1:0]                    out_signal_raised,
  output logic                          out_refused,
  output logic                          out_cooked_valid,
  output logic [tld_pkg::BYTE_W-1:0]    out_cooked_byte,
  output logic                          out_output_stopped,
  output logic [tld_pkg::LINE_W-1:0]    out_lines_ready,
  output logic                          out_last_of_run,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tld_pkg::BYTE_W-1:0]    cfg_data
);

  tld_pkg::tld_status_t st;
  tld_pkg::tld_cmd_t    cmd;

  assign cfg_ready = 1'b1;

  tld_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .st      (st),
    .cmd     (cmd)
  );

  tld_datapath #(
    .RING_DEPTH(RING_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_operation      (in_operation),
    .in_received_byte  (in_received_byte),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_echo_count    (out_echo_count),
    .out_echo_first    (out_echo_first),
    .out_echo_second   (out_echo_second),
    .out_signal_raised (out_signal_raised),
    .out_refused       (out_refused),
    .out_cooked_valid  (out_cooked_valid),
    .out_cooked_byte   (out_cooked_byte),
    .out_output_stopped(out_output_stopped),
    .out_lines_ready   (out_lines_ready),
    .out_last_of_run   (out_last_of_run),
    .cmd               (cmd),
    .st                (st)
  );

endmodule

// File: test/tb_top.sv
module tb_top;
  import tld_pkg::*;

  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_TAKE    = 1'b1;
  localparam int RING_SLOTS   = 64;
  localparam int LONG_HOLD    = 300;

  typedef struct {
    logic [1:0]        echo_count;
    logic [BYTE_W-1:0] echo_first;
    logic [BYTE_W-1:0] echo_second;
    logic [1:0]        signal_raised;
    logic              refused;
    logic              cooked_valid;
    logic [BYTE_W-1:0] cooked_byte;
    logic              output_stopped;
    logic [LINE_W-1:0] lines_ready;
    logic              last_of_run;
  } edit_result_t;

  class line_editor_scoreboard;
    logic [BYTE_W-1:0] regs [8];
    logic [BYTE_W-1:0] ring [RING_SLOTS];
    logic [5:0]        head;
    logic [5:0]        tail;
    logic [LINE_W-1:0] lines;
    logic              stopped;
    edit_result_t      editor_results_q [$];
    edit_result_t      step_results_q [$];
    int                errors;

    function new();
      regs[CFG_MODE]  = RST_MODE;
      regs[CFG_INTR]  = RST_INTR;
      regs[CFG_QUIT]  = RST_QUIT;
      regs[CFG_ERASE] = RST_ERASE;
      regs[CFG_KILL]  = RST_KILL;
      regs[CFG_EOF]   = RST_EOF;
      regs[CFG_START] = RST_START;
      regs[CFG_STOP]  = RST_STOP;
      head = '0;
      tail = '0;
      lines = '0;
      stopped = 1'b0;
      errors = 0;
    endfunction

    function void note_config(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      regs[idx] = val;
    endfunction

    function bit control_byte(input logic [BYTE_W-1:0] c);
      return (c < CH_SPACE) || c[BYTE_W-1];
    endfunction

    function bit line_editable();
      logic [5:0] prev;
      prev = head - 6'd1;
      if (head == tail) return 1'b0;
      return !(ring[prev] == CH_NL || ring[prev] == regs[CFG_EOF]);
    endfunction

    function void emit_result(input logic [1:0] cnt, input logic [BYTE_W-1:0] first, second,
                              input logic [1:0] sig, input logic refd, input logic cv,
                              input logic [BYTE_W-1:0] cb);
      edit_result_t r;
      r.echo_count = cnt;
      r.echo_first = first;
      r.echo_second = second;
      r.signal_raised = sig;
      r.refused = refd;
      r.cooked_valid = cv;
      r.cooked_byte = cb;
      r.output_stopped = stopped;
      r.lines_ready = lines;
      r.last_of_run = 1'b0;
      step_results_q.push_back(r);
    endfunction

    function void edit_line(input logic op, input logic [BYTE_W-1:0] raw);
      logic [BYTE_W-1:0] c;
      logic [BYTE_W-1:0] last;
      logic [BYTE_W-1:0] mode;
      logic [5:0]        nxt;
      logic [1:0]        cnt;
      logic [BYTE_W-1:0] e1;
      logic [BYTE_W-1:0] e2;
      bit                killing;
      bit                walking;
      int                made;
      mode = regs[CFG_MODE];
      made = 0;
      if (op == OP_TAKE) begin
        if (head != tail) begin
          c = ring[tail];
          tail = tail + 6'd1;
          if ((c == CH_NL || c == regs[CFG_EOF]) && lines != 0) lines = lines - 1'b1;
          emit_result(ECHO_NONE, 8'd0, 8'd0, SIG_NONE, 1'b0, 1'b1, c);
        end else begin
          emit_result(ECHO_NONE, 8'd0, 8'd0, SIG_NONE, 1'b0, 1'b0, 8'd0);
        end
        return;
      end
      nxt = head + 6'd1;
      if (nxt == tail) begin
        emit_result(ECHO_NONE, 8'd0, 8'd0, SIG_NONE, 1'b1, 1'b0, 8'd0);
        return;
      end
      c = raw;
      if (c == CH_CR) begin
        if (mode[MB_CRNL]) begin
          c = CH_NL;
        end else if (mode[MB_NOCR]) begin
          emit_result(ECHO_NONE, 8'd0, 8'd0, SIG_NONE, 1'b0, 1'b0, 8'd0);
          return;
        end
      end else if (c == CH_NL && mode[MB_NLCR]) begin
        c = CH_CR;
      end
      if (mode[MB_UCLC] && c >= CH_UPPER_A && c <= CH_UPPER_Z) c = c + CASE_OFS;
      if (mode[MB_CANON]) begin
        if (c == regs[CFG_KILL] || c == regs[CFG_ERASE]) begin
          killing = (c == regs[CFG_KILL]);
          walking = 1'b1;
          while (walking && line_editable()) begin
            head = head - 6'd1;
            last = ring[head];
            if (mode[MB_ECHO]) begin
              if (control_byte(last)) emit_result(ECHO_TWO, CH_DEL, CH_DEL, SIG_NONE, 1'b0, 1'b0, 8'd0);
              else emit_result(ECHO_ONE, CH_DEL, 8'd0, SIG_NONE, 1'b0, 1'b0, 8'd0);
              made++;
            end
            walking = killing;
          end
          if (made == 0) emit_result(ECHO_NONE, 8'd0, 8'd0, SIG_NONE, 1'b0, 1'b0, 8'd0);
          return;
        end
        if (c == regs[CFG_STOP] || c == regs[CFG_START]) begin
          stopped = (c == regs[CFG_STOP]);
          emit_result(ECHO_NONE, 8'd0, 8'd0, SIG_NONE, 1'b0, 1'b0, 8'd0);
          return;
        end
      end
      if (mode[MB_ISIG] && (c == regs[CFG_INTR] || c == regs[CFG_QUIT])) begin
        emit_result(ECHO_NONE, 8'd0, 8'd0, (c == regs[CFG_INTR]) ? SIG_INTR : SIG_QUIT,
                    1'b0, 1'b0, 8'd0);
        return;
      end
      if ((c == CH_NL || c == regs[CFG_EOF]) && lines < RING_SLOTS) lines = lines + 1'b1;
      cnt = ECHO_NONE;
      e1 = 8'd0;
      e2 = 8'd0;
      if (mode[MB_ECHO]) begin
        if (c == CH_NL) begin
          cnt = ECHO_TWO;
          e1 = CH_NL;
          e2 = CH_CR;
        end else if (control_byte(c)) begin
          if (mode[MB_ECHOCTL]) begin
            cnt = ECHO_TWO;
            e1 = CH_CARET;
            e2 = c + CTRL_OFS;
          end
        end else begin
          cnt = ECHO_ONE;
          e1 = c;
        end
      end
      ring[head] = c;
      head = head + 6'd1;
      emit_result(cnt, e1, e2, SIG_NONE, 1'b0, 1'b0, 8'd0);
    endfunction

    function void note_request(input logic op, input logic [BYTE_W-1:0] raw);
      step_results_q.delete();
      edit_line(op, raw);
      step_results_q[step_results_q.size()-1].last_of_run = 1'b1;
      foreach (step_results_q[i]) editor_results_q.push_back(step_results_q[i]);
    endfunction

    function void compare(input string field, input logic [BYTE_W-1:0] want, seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, field, want, seen);
      end
    endfunction

    function void check_result(input edit_result_t seen);
      edit_result_t want;
      if (editor_results_q.size() == 0) begin
        errors++;
        $display("%0t: result expected none actual echo %0d %0d %0d cooked %0d %0d",
                 $time, seen.echo_count, seen.echo_first, seen.echo_second,
                 seen.cooked_valid, seen.cooked_byte);
        return;
      end
      want = editor_results_q.pop_front();
      compare("echo_count", want.echo_count, seen.echo_count);
      compare("echo_first", want.echo_first, seen.echo_first);
      compare("echo_second", want.echo_second, seen.echo_second);
      compare("signal_raised", want.signal_raised, seen.signal_raised);
      compare("refused", want.refused, seen.refused);
      compare("cooked_valid", want.cooked_valid, seen.cooked_valid);
      compare("cooked_byte", want.cooked_byte, seen.cooked_byte);
      compare("output_stopped", want.output_stopped, seen.output_stopped);
      compare("lines_ready", want.lines_ready, seen.lines_ready);
      compare("last_of_run", want.last_of_run, seen.last_of_run);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_operation;
  logic [BYTE_W-1:0]    in_received_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           out_echo_count;
  logic [BYTE_W-1:0]    out_echo_first;
  logic [BYTE_W-1:0]    out_echo_second;
  logic [1:0]           out_signal_raised;
  logic                 out_refused;
  logic                 out_cooked_valid;
  logic [BYTE_W-1:0]    out_cooked_byte;
  logic                 out_output_stopped;
  logic [LINE_W-1:0]    out_lines_ready;
  logic                 out_last_of_run;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;

  line_editor_scoreboard sb;
  edit_result_t          seen_result;
  logic [BYTE_W-1:0]     reg_vals [8];
  int                    burst_left;
  bit                    hold_request;

  logic [8:0] directed_q [$] = '{
    {OP_TAKE, 8'h00}, {OP_RECEIVE, RST_ERASE},
    {OP_RECEIVE, 8'h41}, {OP_RECEIVE, 8'h7E}, {OP_RECEIVE, 8'h00}, {OP_RECEIVE, 8'hFF},
    {OP_RECEIVE, 8'h80}, {OP_RECEIVE, 8'h01},
    {OP_RECEIVE, RST_ERASE}, {OP_RECEIVE, RST_ERASE},
    {OP_RECEIVE, CH_CR}, {OP_RECEIVE, RST_ERASE},
    {OP_RECEIVE, 8'h78}, {OP_RECEIVE, 8'h79}, {OP_RECEIVE, 8'h1F}, {OP_RECEIVE, RST_KILL},
    {OP_RECEIVE, RST_INTR}, {OP_RECEIVE, RST_QUIT}, {OP_RECEIVE, RST_STOP},
    {OP_RECEIVE, RST_START}, {OP_RECEIVE, RST_EOF}, {OP_RECEIVE, CH_NL},
    {OP_TAKE, 8'hFF}, {OP_TAKE, 8'h00}, {OP_TAKE, 8'h5A}
  };

  terminal_line_discipline_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_received_byte  (in_received_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_echo_count    (out_echo_count),
    .out_echo_first    (out_echo_first),
    .out_echo_second   (out_echo_second),
    .out_signal_raised (out_signal_raised),
    .out_refused       (out_refused),
    .out_cooked_valid  (out_cooked_valid),
    .out_cooked_byte   (out_cooked_byte),
    .out_output_stopped(out_output_stopped),
    .out_lines_ready   (out_lines_ready),
    .out_last_of_run   (out_last_of_run),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("tb_top: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_result.echo_count = out_echo_count;
      seen_result.echo_first = out_echo_first;
      seen_result.echo_second = out_echo_second;
      seen_result.signal_raised = out_signal_raised;
      seen_result.refused = out_refused;
      seen_result.cooked_valid = out_cooked_valid;
      seen_result.cooked_byte = out_cooked_byte;
      seen_result.output_stopped = out_output_stopped;
      seen_result.lines_ready = out_lines_ready;
      seen_result.last_of_run = out_last_of_run;
      sb.check_result(seen_result);
    end
  end

  // display side back-pressure
  initial begin : stall_gen
    int pattern;
    int pattern_left;
    int tick;
    pattern = 0;
    pattern_left = 0;
    tick = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern = $urandom_range(0, 3);
          pattern_left = $urandom_range(20, 120);
        end
        pattern_left--;
        tick++;
        case (pattern)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ((tick % 5) < 2);
          default: out_stall <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  task automatic offer(input logic op, input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_operation <= op;
    in_received_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, b);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.editor_results_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(idx, val);
    reg_vals[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_config(input logic [BYTE_W-1:0] mode, intr, quit, erase, kill, eof,
                             resume, pause);
    write_reg(CFG_MODE, mode);
    write_reg(CFG_INTR, intr);
    write_reg(CFG_QUIT, quit);
    write_reg(CFG_ERASE, erase);
    write_reg(CFG_KILL, kill);
    write_reg(CFG_EOF, eof);
    write_reg(CFG_START, resume);
    write_reg(CFG_STOP, pause);
  endtask

  // typed text with line ends, editing bytes and noise
  function automatic logic [BYTE_W-1:0] pick_byte(input int nl_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < nl_pct) return ($urandom_range(0, 1) != 0) ? CH_NL : CH_CR;
    if (r < nl_pct + 10) return reg_vals[$urandom_range(1, 7)];
    if (r < nl_pct + 25) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(32, 126));
  endfunction

  task automatic run_phase(input int count, input int take_pct, input int nl_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < take_pct) offer(OP_TAKE, 8'($urandom_range(0, 255)));
      else offer(OP_RECEIVE, pick_byte(nl_pct));
    end
    settle();
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_RECEIVE;
    in_received_byte = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MODE;
    cfg_data = '0;
    burst_left = 0;
    hold_request = 1'b0;
    reg_vals[CFG_MODE]  = RST_MODE;
    reg_vals[CFG_INTR]  = RST_INTR;
    reg_vals[CFG_QUIT]  = RST_QUIT;
    reg_vals[CFG_ERASE] = RST_ERASE;
    reg_vals[CFG_KILL]  = RST_KILL;
    reg_vals[CFG_EOF]   = RST_EOF;
    reg_vals[CFG_START] = RST_START;
    reg_vals[CFG_STOP]  = RST_STOP;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_q[i]) offer(directed_q[i][8], directed_q[i][7:0]);
    settle();

    load_config(8'hFF, RST_INTR, RST_QUIT, RST_ERASE, RST_KILL, RST_EOF, RST_START, RST_STOP);
    hold_request = 1'b1;
    run_phase(50, 25, 15);

    // long lines, few takes: ring fills and refuses
    load_config(8'hD0, RST_INTR, RST_QUIT, RST_ERASE, RST_KILL, RST_EOF, RST_START, RST_STOP);
    run_phase(80, 3, 4);

    load_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    run_phase(40, 60, 15);

    // overlapping editing bytes
    load_config(8'h5A, 8'h03, 8'h03, 8'h08, 8'h08, 8'h04, 8'h13, 8'h13);
    run_phase(45, 25, 10);

    load_config(8'h7E, 8'h7F, 8'h11, 8'h7F, 8'h15, 8'hFF, 8'h11, 8'h7F);
    run_phase(45, 25, 10);

    load_config(8'hF2, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_phase(40, 30, 10);

    load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_phase(40, 30, 12);

    load_config(RST_MODE, RST_INTR, RST_QUIT, RST_ERASE, RST_KILL, RST_EOF, RST_START,
                RST_STOP);
    run_phase(40, 50, 15);

    if (sb.errors == 0 && sb.editor_results_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: terminal_line_discipline_top.f
sv/tld_pkg.sv
sv/tld_ram.sv
sv/tld_ctrl.sv
sv/tld_datapath.sv
sv/terminal_line_discipline_top.sv
test/tb_top.sv
